// ===== design/owen_scrambled_sobol_sampler_macros.svh =====
// assertion macros shared by the sampler rtl
`ifndef OWEN_SCRAMBLED_SOBOL_SAMPLER_MACROS_SVH
`define OWEN_SCRAMBLED_SOBOL_SAMPLER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define OSS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("sampler assertion failed");
// next-cycle implication, disabled while in reset
`define OSS_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("sampler assertion failed");
`else
`define OSS_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define OSS_ASSERT_NXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// ===== design/oss_pkg.sv =====
`timescale 1ns / 1ps

package oss_pkg;

  // multiply-xor steps of the laine-karras hash
  localparam int HASH_STEPS = 4;
  // stages up to and including the index hash
  localparam int IDX_STAGES = HASH_STEPS + 1;
  // index hash stages, then one gray/direction stage, then the coordinate hashes
  localparam int NUM_STAGES = IDX_STAGES + HASH_STEPS + 1;

  localparam logic [31:0] HASH_MUL [HASH_STEPS] = '{
    32'h6c50b47c, 32'hb82f1e52, 32'hc7afe638, 32'h8d22f6e6
  };

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_INDEX_SEED = 2'd0,
    REG_DIM0_SEED  = 2'd1,
    REG_DIM1_SEED  = 2'd2
  } cfg_reg_t;

  typedef logic [1:0] cfg_index_t;

  function automatic logic [31:0] flip32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  // one multiply-xor step, product wraps to 32 bits
  function automatic logic [31:0] lk_step(input logic [31:0] v, input logic [31:0] c);
    logic [31:0] p;
    p = v * c;
    return v ^ p;
  endfunction

  // second sobol dimension direction words
  function automatic logic [31:0] dir1_word(input logic [4:0] k);
    logic [31:0] w;
    case (k)
      5'd0:  w = 32'h80000000;
      5'd1:  w = 32'hc0000000;
      5'd2:  w = 32'hc0000000;
      5'd3:  w = 32'h90000000;
      5'd4:  w = 32'hb8000000;
      5'd5:  w = 32'he8000000;
      5'd6:  w = 32'he2000000;
      5'd7:  w = 32'ha3000000;
      5'd8:  w = 32'h8b000000;
      5'd9:  w = 32'hce400000;
      5'd10: w = 32'hcee00000;
      5'd11: w = 32'h9aa00000;
      5'd12: w = 32'hb0080000;
      5'd13: w = 32'he40c0000;
      5'd14: w = 32'hee0c0000;
      5'd15: w = 32'haa090000;
      5'd16: w = 32'h808b8000;
      5'd17: w = 32'hc0ce8000;
      5'd18: w = 32'hc0ce2000;
      5'd19: w = 32'h909a3000;
      5'd20: w = 32'hb8b0b000;
      5'd21: w = 32'he8e4e400;
      5'd22: w = 32'he2eeee00;
      5'd23: w = 32'ha3aaaa00;
      5'd24: w = 32'h8b800080;
      5'd25: w = 32'hce8000c0;
      5'd26: w = 32'hce2000c0;
      5'd27: w = 32'h9a300090;
      5'd28: w = 32'hb0b000b8;
      5'd29: w = 32'he4e400e8;
      5'd30: w = 32'heeee00e2;
      default: w = 32'haaaa00a3;
    endcase
    return w;
  endfunction

  // xor of the direction words picked by the gray code bits
  function automatic logic [31:0] dim1_point(input logic [31:0] gray);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < 32; k++) begin
      if (gray[k]) begin
        acc = acc ^ dir1_word(5'(k));
      end
    end
    return acc;
  endfunction

endpackage

// ===== design/owen_scrambled_sobol_sampler.sv =====
`timescale 1ns / 1ps
// owen-scrambled 2-d sobol sampler
// input channel: in_valid / in_stall carry one 32-bit sample index per transaction
// output channel: out_valid / out_stall carry point_x and point_y, raw 32-bit
//   fractions scaled by 2^32, one output transaction per input transaction, in order
// config channel: cfg_valid / cfg_ready, cfg_ready is always high; index 0 is the
//   index seed, 1 the x seed, 2 the y seed, index 3 is ignored; write only while idle
// path: out_valid rises once an accepted index has passed the ten register stages
//   (index add, four hash multiplies, gray/direction xor, four more multiplies)
// throughput: one index per cycle while in_stall is low; each multiply stage holds
//   one 32x32 constant multiply per lane, the add and gray/direction stages hold none
// stall: each stage advances when it is empty or the stage after it advances, so
//   bubbles close up and new indexes enter while a result waits at the output;
//   in_stall rises only when every stage is full and out_stall is high
// reset: synchronous, active low; clears all stage valid bits and the three seeds
module owen_scrambled_sobol_sampler (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_sample_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_point_x,
  output logic [31:0]       out_point_y,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  oss_pkg::cfg_index_t cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import oss_pkg::*;

  `include "owen_scrambled_sobol_sampler_macros.svh"

  // configuration registers
  logic [31:0] index_seed_r;
  logic [31:0] dim0_seed_r;
  logic [31:0] dim1_seed_r;

  // per-stage valid bits and advance enables
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] en;

  // index hash stages: stage 0 is the seed add, 1..4 the multiply-xor steps
  logic [31:0] hash_r   [IDX_STAGES];
  logic [31:0] hash_nxt [IDX_STAGES];

  // coordinate stages: 0 is gray code (x) or its direction xor (y) + seed add, 1..4 the multiply-xor steps
  logic [31:0] x_r   [HASH_STEPS+1];
  logic [31:0] x_nxt [HASH_STEPS+1];
  logic [31:0] y_r   [HASH_STEPS+1];
  logic [31:0] y_nxt [HASH_STEPS+1];

  logic [31:0] shuffled;
  logic [31:0] gray;

  assign cfg_ready = 1'b1;

  // config writes, out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_seed_r <= '0;
      dim0_seed_r  <= '0;
      dim1_seed_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INDEX_SEED: index_seed_r <= cfg_wdata;
        REG_DIM0_SEED:  dim0_seed_r  <= cfg_wdata;
        REG_DIM1_SEED:  dim1_seed_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or its successor advances
  always_comb begin
    en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  // datapath next values
  always_comb begin
    // index shuffle: reverse, add seed, hash
    hash_nxt[0] = flip32(in_sample_index) + index_seed_r;
    for (int k = 1; k < IDX_STAGES; k++) begin
      hash_nxt[k] = lk_step(hash_r[k-1], HASH_MUL[k-1]);
    end

    // reverse back to get the shuffled index, then its gray code
    shuffled = flip32(hash_r[IDX_STAGES-1]);
    gray     = shuffled ^ (shuffled >> 1);

    // identity directions give x = reverse(gray), so the scramble's
    // leading reversal cancels and the hash starts from gray itself
    x_nxt[0] = gray + dim0_seed_r;
    y_nxt[0] = flip32(dim1_point(gray)) + dim1_seed_r;
    for (int k = 1; k <= HASH_STEPS; k++) begin
      x_nxt[k] = lk_step(x_r[k-1], HASH_MUL[k-1]);
      y_nxt[k] = lk_step(y_r[k-1], HASH_MUL[k-1]);
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < IDX_STAGES; k++) begin
      if (en[k]) begin
        hash_r[k] <= hash_nxt[k];
      end
    end
    for (int k = 0; k <= HASH_STEPS; k++) begin
      if (en[IDX_STAGES+k]) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // final reversal of the coordinate scramble is wiring only
  assign out_valid   = valid_r[NUM_STAGES-1];
  assign out_point_x = flip32(x_r[HASH_STEPS]);
  assign out_point_y = flip32(y_r[HASH_STEPS]);

  // backpressure on the input only comes from a full pipe held at the output
  `OSS_ASSERT_IMP(a_stall_from_output, clk, rst_n, in_stall, out_valid && out_stall)
  // an accepted index always lands in the first stage
  `OSS_ASSERT_NXT(a_accept_fills_stage0, clk, rst_n, in_valid && !in_stall, valid_r[0])
  // a taken result with nothing behind it leaves the output empty
  `OSS_ASSERT_NXT(a_drain_empties_out, clk, rst_n,
                  out_valid && !out_stall && !valid_r[NUM_STAGES-2], !out_valid)

endmodule
